// ===== hdl/gfcm_pkg.sv =====
`timescale 1ns / 1ps
package gfcm_pkg;

	localparam int GRID_SIZE = 64;
	localparam int COORD_W   = 6;
	localparam int FACE_N    = 6;
	localparam int BASE_W    = 16;
	localparam int FLOOR_W   = 15;
	localparam int WALL_W    = 17;
	localparam int CEIL_W    = 15;

	localparam int BIT_FLOOR = 0;
	localparam int BIT_NORTH = 1;
	localparam int BIT_SOUTH = 2;
	localparam int BIT_WEST  = 3;
	localparam int BIT_EAST  = 4;
	localparam int BIT_CEIL  = 5;

	typedef enum logic [1:0] {
		MESH_FLOOR = 2'd0,
		MESH_WALL  = 2'd1,
		MESH_CEIL  = 2'd2
	} mesh_kind_t;

	typedef enum logic [2:0] {
		FACE_FLOOR = 3'd0,
		FACE_CEIL  = 3'd1,
		FACE_NORTH = 3'd2,
		FACE_SOUTH = 3'd3,
		FACE_WEST  = 3'd4,
		FACE_EAST  = 3'd5
	} face_kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic               has_floor;
		logic               has_ceiling;
		logic               is_wall;
		logic               north_wall;
		logic               south_wall;
		logic               west_wall;
		logic               east_wall;
		logic               first_cell;
	} cell_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [FACE_N-1:0]  mask;
		logic [FLOOR_W-1:0] floor_base;
		logic [BASE_W-1:0]  wall_base;
		logic [CEIL_W-1:0]  ceil_base;
	} cell_job_t;

	function automatic face_kind_t face_of(input logic [FACE_N-1:0] onehot);
		face_kind_t f;
		f = FACE_EAST;
		if (onehot[BIT_FLOOR])
			f = FACE_FLOOR;
		else if (onehot[BIT_NORTH])
			f = FACE_NORTH;
		else if (onehot[BIT_SOUTH])
			f = FACE_SOUTH;
		else if (onehot[BIT_WEST])
			f = FACE_WEST;
		else if (onehot[BIT_CEIL])
			f = FACE_CEIL;
		return f;
	endfunction

endpackage

// ===== hdl/gfcm_cell_if.sv =====
`timescale 1ns / 1ps
interface gfcm_cell_if;
	logic       valid;
	logic       ready;
	logic [5:0] cell_row;
	logic [5:0] cell_col;
	logic       has_floor;
	logic       has_ceiling;
	logic       is_wall;
	logic       north_wall;
	logic       south_wall;
	logic       west_wall;
	logic       east_wall;
	logic       first_cell;

	modport source (output valid, cell_row, cell_col, has_floor, has_ceiling, is_wall,
		north_wall, south_wall, west_wall, east_wall, first_cell, input ready);
	modport sink (input valid, cell_row, cell_col, has_floor, has_ceiling, is_wall,
		north_wall, south_wall, west_wall, east_wall, first_cell, output ready);
endinterface

// ===== hdl/gfcm_quad_if.sv =====
`timescale 1ns / 1ps
interface gfcm_quad_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mesh_kind;
	logic [2:0]  face_kind;
	logic [5:0]  quad_row;
	logic [5:0]  quad_col;
	logic [15:0] base_vertex;
	logic        last_quad;

	modport source (output valid, mesh_kind, face_kind, quad_row, quad_col, base_vertex,
		last_quad, input ready);
	modport sink (input valid, mesh_kind, face_kind, quad_row, quad_col, base_vertex,
		last_quad, output ready);
endinterface

// ===== hdl/gfcm_cull.sv =====
`timescale 1ns / 1ps
module gfcm_cull
	import gfcm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      accept,
	input  cell_in_t  cur,
	output cell_job_t job
);

	logic [FLOOR_W-1:0] floor_total_q;
	logic [WALL_W-1:0]  wall_total_q;
	logic [CEIL_W-1:0]  ceil_total_q;

	logic [FLOOR_W-1:0] floor_start;
	logic [WALL_W-1:0]  wall_start;
	logic [CEIL_W-1:0]  ceil_start;
	logic               open_n, open_s, open_w, open_e;
	logic [3:0]         wall_faces;
	logic [2:0]         wall_cnt;

	always_comb begin
		floor_start = cur.first_cell ? '0 : floor_total_q;
		wall_start  = cur.first_cell ? '0 : wall_total_q;
		ceil_start  = cur.first_cell ? '0 : ceil_total_q;

		open_n = (cur.cell_row == '0) || !cur.north_wall;
		open_s = ((int'(cur.cell_row) + 1) >= GRID_SIZE) || !cur.south_wall;
		open_w = (cur.cell_col == '0) || !cur.west_wall;
		open_e = ((int'(cur.cell_col) + 1) >= GRID_SIZE) || !cur.east_wall;
		wall_faces = {open_e, open_w, open_s, open_n} & {4{cur.is_wall}};
		wall_cnt = 3'({2'b00, wall_faces[0]} + {2'b00, wall_faces[1]}
			+ {2'b00, wall_faces[2]} + {2'b00, wall_faces[3]});

		job.row        = cur.cell_row;
		job.col        = cur.cell_col;
		job.mask       = '0;
		job.mask[BIT_FLOOR] = cur.has_floor;
		job.mask[BIT_NORTH] = wall_faces[0];
		job.mask[BIT_SOUTH] = wall_faces[1];
		job.mask[BIT_WEST]  = wall_faces[2];
		job.mask[BIT_EAST]  = wall_faces[3];
		job.mask[BIT_CEIL]  = cur.has_ceiling;
		job.floor_base = floor_start;
		job.wall_base  = wall_start[BASE_W-1:0];
		job.ceil_base  = ceil_start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_total_q <= '0;
			wall_total_q  <= '0;
			ceil_total_q  <= '0;
		end else if (accept) begin
			floor_total_q <= floor_start + (cur.has_floor ? FLOOR_W'(4) : FLOOR_W'(0));
			wall_total_q  <= wall_start + WALL_W'({wall_cnt, 2'b00});
			ceil_total_q  <= ceil_start + (cur.has_ceiling ? CEIL_W'(4) : CEIL_W'(0));
		end
	end

endmodule

// ===== hdl/gfcm_emit.sv =====
`timescale 1ns / 1ps
module gfcm_emit
	import gfcm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  cell_job_t    job,
	output logic         take,
	gfcm_quad_if.source  quad
);

	logic [COORD_W-1:0] row_s1;
	logic [COORD_W-1:0] col_s1;
	logic [FACE_N-1:0]  mask_s1;
	logic [FLOOR_W-1:0] floor_base_s1;
	logic [BASE_W-1:0]  wall_base_s1;
	logic [CEIL_W-1:0]  ceil_base_s1;

	logic               out_valid_q;
	mesh_kind_t         mesh_q;
	face_kind_t         face_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [BASE_W-1:0]  base_q;
	logic               last_q;

	logic [FACE_N-1:0]  pick;
	logic [FACE_N-1:0]  rest;
	logic               load_out;
	logic               fire;
	logic               is_wall_face;
	mesh_kind_t         mesh_sel;
	logic [BASE_W-1:0]  base_sel;

	always_comb begin
		pick = mask_s1 & (~mask_s1 + FACE_N'(1));
		rest = mask_s1 & ~pick;
		load_out = !out_valid_q || quad.ready;
		fire = load_out && (mask_s1 != '0);
		take = (mask_s1 == '0) || (fire && (rest == '0));
		is_wall_face = !pick[BIT_FLOOR] && !pick[BIT_CEIL];
		if (pick[BIT_FLOOR]) begin
			mesh_sel = MESH_FLOOR;
			base_sel = BASE_W'(floor_base_s1);
		end else if (pick[BIT_CEIL]) begin
			mesh_sel = MESH_CEIL;
			base_sel = BASE_W'(ceil_base_s1);
		end else begin
			mesh_sel = MESH_WALL;
			base_sel = wall_base_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (accept) begin
			mask_s1 <= job.mask;
		end else if (fire) begin
			mask_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1        <= job.row;
			col_s1        <= job.col;
			floor_base_s1 <= job.floor_base;
			wall_base_s1  <= job.wall_base;
			ceil_base_s1  <= job.ceil_base;
		end else if (fire && is_wall_face) begin
			wall_base_s1 <= wall_base_s1 + BASE_W'(4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			mesh_q <= mesh_sel;
			face_q <= face_of(pick);
			row_q  <= row_s1;
			col_q  <= col_s1;
			base_q <= base_sel;
			last_q <= (rest == '0);
		end
	end

	assign quad.valid       = out_valid_q;
	assign quad.mesh_kind   = mesh_q;
	assign quad.face_kind   = face_q;
	assign quad.quad_row    = row_q;
	assign quad.quad_col    = col_q;
	assign quad.base_vertex = base_q;
	assign quad.last_quad   = last_q;

endmodule

// ===== hdl/grid_face_culling_mesher_unit.sv =====
`timescale 1ns / 1ps
// Face-culling mesher: takes grid cells in row-major order and sends one quad
// item per visible face (floor, north, south, west, east, ceiling, in that
// order), each with its mesh, face, cell and base vertex in that mesh. Set
// first_cell on the first cell of a grid to restart the three vertex counters.
// A cell sends one visible quad per cycle while the output is not stalled by
// quad ready; the single quad output register sets that rate. The next cell is
// taken in the cycle its predecessor's last quad moves to the output register,
// and a cell with no visible face lets the next cell in on the cycle after it.
module grid_face_culling_mesher_unit
	import gfcm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	gfcm_cell_if.sink   cells,
	gfcm_quad_if.source quad
);

	cell_in_t  cell_in;
	cell_job_t job;
	logic      take;
	logic      accept;

	always_comb begin
		cell_in.cell_row    = cells.cell_row;
		cell_in.cell_col    = cells.cell_col;
		cell_in.has_floor   = cells.has_floor;
		cell_in.has_ceiling = cells.has_ceiling;
		cell_in.is_wall     = cells.is_wall;
		cell_in.north_wall  = cells.north_wall;
		cell_in.south_wall  = cells.south_wall;
		cell_in.west_wall   = cells.west_wall;
		cell_in.east_wall   = cells.east_wall;
		cell_in.first_cell  = cells.first_cell;
	end

	assign cells.ready = take;
	assign accept      = cells.valid && take;

	gfcm_cull u_cull (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.cur    (cell_in),
		.job    (job)
	);

	gfcm_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.job    (job),
		.take   (take),
		.quad   (quad)
	);

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import gfcm_pkg::*;

	typedef struct packed {
		mesh_kind_t        mesh;
		face_kind_t        face;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [BASE_W-1:0]  base;
		logic               last;
	} quad_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	gfcm_cell_if cell_ch();
	gfcm_quad_if quad_ch();

	grid_face_culling_mesher_unit DUT (clk, arst_n, cell_ch, quad_ch);

	always #5 clk = ~clk;

	quad_rec_t          quad_expected[$];
	logic [FLOOR_W-1:0] floor_verts;
	logic [WALL_W-1:0]  wall_verts;
	logic [CEIL_W-1:0]  ceil_verts;
	int                 mismatches;
	bit                 idle_on;
	bit                 wall_map [GRID_SIZE][GRID_SIZE];

	function automatic quad_rec_t make_quad(input mesh_kind_t m, input face_kind_t f,
		input cell_in_t c, input logic [BASE_W-1:0] b);
		quad_rec_t r;
		r.mesh = m;
		r.face = f;
		r.row  = c.cell_row;
		r.col  = c.cell_col;
		r.base = b;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void predict_quads(input cell_in_t c);
		quad_rec_t  batch[$];
		logic [3:0] open_side;
		face_kind_t side_face [4];
		side_face = '{FACE_NORTH, FACE_SOUTH, FACE_WEST, FACE_EAST};
		if (c.first_cell) begin
			floor_verts = '0;
			wall_verts  = '0;
			ceil_verts  = '0;
		end
		if (c.has_floor) begin
			batch.insert(batch.size(),
				make_quad(MESH_FLOOR, FACE_FLOOR, c, BASE_W'(floor_verts)));
			floor_verts = floor_verts + FLOOR_W'(4);
		end
		if (c.is_wall) begin
			open_side[0] = (c.cell_row == 0) || !c.north_wall;
			open_side[1] = (int'(c.cell_row) + 1 >= GRID_SIZE) || !c.south_wall;
			open_side[2] = (c.cell_col == 0) || !c.west_wall;
			open_side[3] = (int'(c.cell_col) + 1 >= GRID_SIZE) || !c.east_wall;
			for (int i = 0; i < 4; i++) begin
				if (open_side[i]) begin
					batch.insert(batch.size(), make_quad(MESH_WALL, side_face[i], c,
						wall_verts[BASE_W-1:0]));
					wall_verts = wall_verts + WALL_W'(4);
				end
			end
		end
		if (c.has_ceiling) begin
			batch.insert(batch.size(),
				make_quad(MESH_CEIL, FACE_CEIL, c, BASE_W'(ceil_verts)));
			ceil_verts = ceil_verts + CEIL_W'(4);
		end
		if (batch.size() > 0)
			batch[batch.size()-1].last = 1'b1;
		foreach (batch[i])
			quad_expected.insert(quad_expected.size(), batch[i]);
	endfunction

	function automatic cell_in_t cell_of(input int row, input int col, input bit fl,
		input bit ce, input bit wl, input bit [3:0] nswe, input bit first);
		cell_in_t c;
		c.cell_row    = COORD_W'(row);
		c.cell_col    = COORD_W'(col);
		c.has_floor   = fl;
		c.has_ceiling = ce;
		c.is_wall     = wl;
		c.north_wall  = nswe[3];
		c.south_wall  = nswe[2];
		c.west_wall   = nswe[1];
		c.east_wall   = nswe[0];
		c.first_cell  = first;
		return c;
	endfunction

	task automatic send_cell(input cell_in_t c);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			cell_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		cell_ch.valid       <= 1'b1;
		cell_ch.cell_row    <= c.cell_row;
		cell_ch.cell_col    <= c.cell_col;
		cell_ch.has_floor   <= c.has_floor;
		cell_ch.has_ceiling <= c.has_ceiling;
		cell_ch.is_wall     <= c.is_wall;
		cell_ch.north_wall  <= c.north_wall;
		cell_ch.south_wall  <= c.south_wall;
		cell_ch.west_wall   <= c.west_wall;
		cell_ch.east_wall   <= c.east_wall;
		cell_ch.first_cell  <= c.first_cell;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
		predict_quads(c);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		cell_ch.valid <= 1'b0;
		while (quad_expected.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// corners, edges and cells one step in from the border
	task automatic test_border_faces();
		send_cell(cell_of(0, 0, 1, 1, 1, 4'b1111, 1));
		send_cell(cell_of(0, 63, 0, 0, 1, 4'b1111, 0));
		send_cell(cell_of(63, 0, 0, 0, 1, 4'b1111, 0));
		send_cell(cell_of(63, 63, 1, 0, 1, 4'b1111, 0));
		send_cell(cell_of(0, 30, 0, 1, 1, 4'b0111, 0));
		send_cell(cell_of(63, 30, 0, 0, 1, 4'b1011, 0));
		send_cell(cell_of(1, 1, 0, 0, 1, 4'b1111, 0));
		send_cell(cell_of(62, 62, 0, 0, 1, 4'b1111, 0));
	endtask

	task automatic test_face_order();
		send_cell(cell_of(10, 20, 1, 1, 1, 4'b0000, 0));
		send_cell(cell_of(10, 21, 0, 0, 1, 4'b0111, 0));
		send_cell(cell_of(10, 22, 0, 0, 1, 4'b1011, 0));
		send_cell(cell_of(10, 23, 0, 0, 1, 4'b1101, 0));
		send_cell(cell_of(10, 24, 0, 0, 1, 4'b1110, 0));
		send_cell(cell_of(11, 5, 1, 0, 0, 4'b0000, 0));
		send_cell(cell_of(11, 6, 0, 1, 0, 4'b0000, 0));
	endtask

	task automatic test_hidden_cells();
		send_cell(cell_of(20, 20, 0, 0, 1, 4'b1111, 0));
		send_cell(cell_of(20, 21, 1, 1, 0, 4'b1111, 0));
		send_cell(cell_of(20, 22, 0, 0, 0, 4'b0000, 0));
		send_cell(cell_of(0, 0, 0, 0, 0, 4'b1111, 1));
		send_cell(cell_of(0, 1, 1, 1, 1, 4'b0000, 0));
	endtask

	// mostly row-major windows with a consistent wall map, some raw noise
	task automatic random_grids(input int n_cells);
		int          sent;
		int          h;
		int          w;
		int          r0;
		int          c0;
		cell_in_t    c;
		logic [31:0] rnd;
		sent = 0;
		while (sent < n_cells) begin
			if ($urandom_range(0, 4) == 0) begin
				rnd = $urandom;
				c = rnd[$bits(cell_in_t)-1:0];
				send_cell(c);
				sent++;
			end else begin
				h = $urandom_range(1, 4);
				w = $urandom_range(1, 8);
				case ($urandom_range(0, 2))
					0: r0 = 0;
					1: r0 = GRID_SIZE - h;
					default: r0 = $urandom_range(0, GRID_SIZE - h);
				endcase
				case ($urandom_range(0, 2))
					0: c0 = 0;
					1: c0 = GRID_SIZE - w;
					default: c0 = $urandom_range(0, GRID_SIZE - w);
				endcase
				for (int r = r0 - 1; r <= r0 + h; r++)
					for (int k = c0 - 1; k <= c0 + w; k++)
						if (r >= 0 && r < GRID_SIZE && k >= 0 && k < GRID_SIZE)
							wall_map[r][k] = ($urandom_range(0, 9) < 4);
				for (int r = r0; r < r0 + h; r++) begin
					for (int k = c0; k < c0 + w; k++) begin
						c.cell_row    = COORD_W'(r);
						c.cell_col    = COORD_W'(k);
						c.is_wall     = wall_map[r][k];
						c.has_floor   = c.is_wall ? ($urandom_range(0, 9) == 0)
							: ($urandom_range(0, 9) != 0);
						c.has_ceiling = 1'($urandom_range(0, 1));
						c.north_wall  = (r > 0) ? wall_map[r-1][k]
							: 1'($urandom_range(0, 1));
						c.south_wall  = (r + 1 < GRID_SIZE) ? wall_map[r+1][k]
							: 1'($urandom_range(0, 1));
						c.west_wall   = (k > 0) ? wall_map[r][k-1]
							: 1'($urandom_range(0, 1));
						c.east_wall   = (k + 1 < GRID_SIZE) ? wall_map[r][k+1]
							: 1'($urandom_range(0, 1));
						c.first_cell  = (r == r0 && k == c0) ? ($urandom_range(0, 4) != 0)
							: 1'b0;
						send_cell(c);
						sent++;
					end
				end
			end
		end
	endtask

	// six faces per cell, back to back
	task automatic test_all_faces();
		for (int i = 0; i < 40; i++)
			send_cell(cell_of($urandom_range(1, GRID_SIZE - 2), $urandom_range(1, GRID_SIZE - 2),
				1, 1, 1, 4'b0000, i == 0));
	endtask

	initial begin
		quad_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				quad_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			quad_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : quad_check
		quad_rec_t want;
		if (arst_n && quad_ch.valid && quad_ch.ready) begin
			if (quad_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected quad: mesh %0d face %0d row %0d col %0d base %0d last %0b",
						quad_ch.mesh_kind, quad_ch.face_kind, quad_ch.quad_row,
						quad_ch.quad_col, quad_ch.base_vertex, quad_ch.last_quad);
			end else begin
				want = quad_expected.pop_front();
				if (quad_ch.mesh_kind !== want.mesh || quad_ch.face_kind !== want.face
					|| quad_ch.quad_row !== want.row || quad_ch.quad_col !== want.col
					|| quad_ch.base_vertex !== want.base || quad_ch.last_quad !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("quad mismatch at %0t: want %0d/%0d/%0d/%0d/%0d/%0b got %0d/%0d/%0d/%0d/%0d/%0b",
							$time, want.mesh, want.face, want.row, want.col, want.base, want.last,
							quad_ch.mesh_kind, quad_ch.face_kind, quad_ch.quad_row,
							quad_ch.quad_col, quad_ch.base_vertex, quad_ch.last_quad);
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("grid_face_culling_mesher_unit regression: fail");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		idle_on             = 1'b1;
		mismatches          = 0;
		floor_verts         = '0;
		wall_verts          = '0;
		ceil_verts          = '0;
		cell_ch.valid       = 1'b0;
		cell_ch.cell_row    = '0;
		cell_ch.cell_col    = '0;
		cell_ch.has_floor   = 1'b0;
		cell_ch.has_ceiling = 1'b0;
		cell_ch.is_wall     = 1'b0;
		cell_ch.north_wall  = 1'b0;
		cell_ch.south_wall  = 1'b0;
		cell_ch.west_wall   = 1'b0;
		cell_ch.east_wall   = 1'b0;
		cell_ch.first_cell  = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_border_faces();
		test_face_order();
		test_hidden_cells();
		random_grids(160);
		hold_until_drained();
		random_grids(100);
		idle_on = 1'b0;
		random_grids(40);
		test_all_faces();

		cell_ch.valid <= 1'b0;
		while (quad_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && quad_expected.size() == 0)
			$display("grid_face_culling_mesher_unit regression: pass");
		else
			$display("grid_face_culling_mesher_unit regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/gfcm_pkg.sv
hdl/gfcm_cell_if.sv
hdl/gfcm_quad_if.sv
hdl/gfcm_cull.sv
hdl/gfcm_emit.sv
hdl/grid_face_culling_mesher_unit.sv
dv/tb.sv
